FILE: rtl/cbcs_pkg.sv
// Shared types, register indexes and frame tables for the cruise button
// CAN frame scheduler. Depends on nothing.
package cbcs_pkg;

  // burst layout
  localparam int NUM_FRAMES = 11;
  localparam int FRAME_IDX_W = 4;
  localparam logic [FRAME_IDX_W-1:0] LAST_FRAME_IDX = FRAME_IDX_W'(NUM_FRAMES - 1);

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEND_PERIOD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_STEP     = 2'd2;

  // register reset values
  localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd50;
  localparam logic [7:0] SEND_PERIOD_RST    = 8'd15;
  localparam logic [7:0] SPEED_STEP_RST     = 8'd5;
  localparam logic [7:0] SAVED_SPEED_RST    = 8'd90;
  localparam logic [7:0] PERIOD_MAX         = 8'hff;

  // one tick of button levels, 0 means pressed
  typedef struct packed {
    logic onoff_level;
    logic minus_level;
    logic plus_level;
  } in_t;

  // one CAN frame
  typedef struct packed {
    logic [10:0] can_id;
    logic [3:0]  data_length;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [7:0]  data_byte6;
    logic [7:0]  data_byte7;
    logic        last_frame;
  } out_t;

  typedef logic [7:0][7:0] frame_bytes_t;

  // identifier of each frame in the burst
  function automatic logic [10:0] frame_id(input logic [FRAME_IDX_W-1:0] idx);
    logic [10:0] id;
    unique case (idx)
      4'd0:    id = 11'h1d2;
      4'd1:    id = 11'h1d3;
      4'd2:    id = 11'h0aa;
      4'd3:    id = 11'h3b7;
      4'd4:    id = 11'h620;
      4'd5:    id = 11'h3bc;
      4'd6:    id = 11'h2c1;
      4'd7:    id = 11'h224;
      4'd8:    id = 11'h614;
      4'd9:    id = 11'h262;
      4'd10:   id = 11'h260;
      default: id = 11'h000;
    endcase
    return id;
  endfunction

  // fixed data bytes, byte 0 in element 0
  function automatic frame_bytes_t frame_fixed(input logic [FRAME_IDX_W-1:0] idx);
    frame_bytes_t d;
    d = '0;
    unique case (idx)
      4'd0:  d[0] = 8'h10;
      4'd1:  d[1] = 8'h28;
      4'd2: begin
        d[0] = 8'h24; d[1] = 8'h33; d[2] = 8'h24; d[3] = 8'h33;
        d[4] = 8'h24; d[5] = 8'h33; d[6] = 8'h24; d[7] = 8'h33;
      end
      4'd3:  d[7] = 8'h08;
      4'd4: begin
        d[0] = 8'h10; d[3] = 8'h1d; d[4] = 8'hb0; d[5] = 8'h40;
      end
      4'd5:  d[5] = 8'h80;
      4'd6:  d[0] = 8'h08;
      4'd7:  d[7] = 8'h08;
      4'd8: begin
        d[0] = 8'h29; d[2] = 8'h01; d[3] = 8'h30; d[6] = 8'h76;
      end
      4'd9: begin
        d[3] = 8'h03; d[4] = 8'h6c;
      end
      4'd10: begin
        d[0] = 8'h08; d[1] = 8'hff; d[2] = 8'hfb; d[5] = 8'hff;
        d[6] = 8'hdc; d[7] = 8'h47;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  // mod-256 sum over id bytes, the data length of eight and bytes 0 to 6
  function automatic logic [7:0] frame_sum(input frame_bytes_t d, input logic [10:0] id);
    logic [7:0] s;
    s = {5'd0, id[10:8]} + id[7:0] + 8'd8;
    for (int k = 0; k < 7; k++) begin
      s = s + d[k];
    end
    return s;
  endfunction

  // full frame from its position in the burst and the captured cruise state
  function automatic out_t build_frame(input logic [FRAME_IDX_W-1:0] idx,
                                       input logic on, input logic [7:0] speed);
    frame_bytes_t d;
    logic [10:0]  id;
    out_t         o;
    d  = frame_fixed(idx);
    id = frame_id(idx);
    if (idx == 4'd0) begin
      d[0] = d[0] | {2'b00, on, 5'd0};
      d[6] = {on, 7'd0};
      d[7] = frame_sum(d, id);
    end else if (idx == 4'd1) begin
      d[1] = d[1] | {on, 7'd0};
      d[2] = speed;
      d[7] = frame_sum(d, id);
    end else if (idx == 4'd8) begin
      d[7] = frame_sum(d, id);
    end
    o.can_id      = id;
    o.data_length = (idx == 4'd9) ? 4'd5 : 4'd8;
    o.data_byte0  = d[0];
    o.data_byte1  = d[1];
    o.data_byte2  = d[2];
    o.data_byte3  = d[3];
    o.data_byte4  = d[4];
    o.data_byte5  = d[5];
    o.data_byte6  = d[6];
    o.data_byte7  = d[7];
    o.last_frame  = (idx == LAST_FRAME_IDX);
    return o;
  endfunction

endpackage

FILE: rtl/cruise_buttons_can_frame_scheduler.sv
// Cruise button debouncer and CAN frame burst scheduler, top level.
// Depends on cbcs_pkg for payload types, register indexes and frame tables.
//
// Each input item is one millisecond tick of three active-low button levels.
// Debounce, cruise toggle, speed step and the period counter all update at
// the accepting edge, so ticks that cause no burst go through at one per
// cycle while in_ready is high. A tick that causes a burst hands the cruise
// state to the frame sequencer, which shows its eleven frames on the output
// one per cycle while out_ready is high. One further burst can wait behind
// the active one; while it waits, in_ready is low. Sustained, the rate of
// bursting ticks is set by how fast the output takes frames. Configuration
// writes take effect at the next edge.
module cruise_buttons_can_frame_scheduler #(
  parameter int HOLD_COUNT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cbcs_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cbcs_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [cbcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);
  import cbcs_pkg::*;

  localparam int CmpW = (HOLD_COUNT_BITS > 8) ? HOLD_COUNT_BITS : 8;
  localparam logic [HOLD_COUNT_BITS-1:0] HoldMax = '1;

  // configuration registers
  logic [7:0] debounce_ticks;
  logic [7:0] send_period;
  logic [7:0] speed_step;

  // tick state
  logic                       cruise_on, cruise_on_next;
  logic [7:0]                 target_speed, target_speed_next;
  logic [7:0]                 saved_speed, saved_speed_next;
  logic [2:0]                 prev_level;
  logic [2:0]                 armed, armed_next;
  logic [HOLD_COUNT_BITS-1:0] hold [3];
  logic [HOLD_COUNT_BITS-1:0] hold_next [3];
  logic [7:0]                 period_count, period_count_next;
  logic [7:0]                 period_inc;
  logic [2:0]                 level;
  logic [2:0]                 fire;
  logic                       burst;

  // burst sequencer
  logic                   act_valid;
  logic [FRAME_IDX_W-1:0] act_idx;
  logic                   act_on;
  logic [7:0]             act_speed;
  logic                   pend_valid;
  logic                   pend_on;
  logic [7:0]             pend_speed;
  logic                   in_fire;
  logic                   frame_done;
  logic                   act_free;
  logic                   burst_req;

  assign level = {in_data.plus_level, in_data.minus_level, in_data.onoff_level};

  // per-button debounce
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (level[b] != prev_level[b]) begin
        armed_next[b] = 1'b1;
        hold_next[b]  = '0;
      end else begin
        armed_next[b] = armed[b];
        hold_next[b]  = (hold[b] != HoldMax) ? hold[b] + 1'b1 : hold[b];
      end
      fire[b] = armed_next[b] && !level[b] &&
                (CmpW'(hold_next[b]) >= CmpW'(debounce_ticks));
      if (fire[b]) begin
        armed_next[b] = 1'b0;
      end
    end
  end

  // cruise toggle then minus then plus
  always_comb begin
    cruise_on_next    = cruise_on;
    target_speed_next = target_speed;
    saved_speed_next  = saved_speed;
    if (fire[0]) begin
      cruise_on_next = !cruise_on;
      if (!cruise_on) begin
        target_speed_next = saved_speed;
      end
    end
    if (fire[1]) begin
      target_speed_next = target_speed_next - speed_step;
      saved_speed_next  = target_speed_next;
    end
    if (fire[2]) begin
      target_speed_next = target_speed_next + speed_step;
      saved_speed_next  = target_speed_next;
    end
  end

  // burst period
  always_comb begin
    period_inc        = (period_count != PERIOD_MAX) ? period_count + 8'd1 : period_count;
    burst             = fire[0] || (period_inc >= send_period);
    period_count_next = burst ? 8'd0 : period_inc;
  end

  assign in_ready   = !pend_valid;
  assign in_fire    = in_valid && in_ready;
  assign burst_req  = in_fire && burst;
  assign frame_done = act_valid && out_ready;
  assign act_free   = !act_valid || (frame_done && act_idx == LAST_FRAME_IDX);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_TICKS_RST;
      send_period    <= SEND_PERIOD_RST;
      speed_step     <= SPEED_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        REG_SEND_PERIOD:    send_period    <= cfg_data;
        REG_SPEED_STEP:     speed_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_on    <= 1'b0;
      target_speed <= 8'd0;
      saved_speed  <= SAVED_SPEED_RST;
      prev_level   <= '0;
      armed        <= '0;
      period_count <= 8'd0;
      for (int b = 0; b < 3; b++) begin
        hold[b] <= '0;
      end
    end else if (in_fire) begin
      cruise_on    <= cruise_on_next;
      target_speed <= target_speed_next;
      saved_speed  <= saved_speed_next;
      prev_level   <= level;
      armed        <= armed_next;
      period_count <= period_count_next;
      for (int b = 0; b < 3; b++) begin
        hold[b] <= hold_next[b];
      end
    end
  end

  // active burst and one waiting burst
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid  <= 1'b0;
      act_idx    <= '0;
      pend_valid <= 1'b0;
    end else if (act_free) begin
      act_idx <= '0;
      if (pend_valid) begin
        act_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        act_valid <= burst_req;
      end
    end else begin
      if (frame_done) begin
        act_idx <= act_idx + 1'b1;
      end
      if (burst_req) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // captured cruise state for the frames
  always_ff @(posedge clk) begin
    if (act_free) begin
      if (pend_valid) begin
        act_on    <= pend_on;
        act_speed <= pend_speed;
      end else begin
        act_on    <= cruise_on_next;
        act_speed <= target_speed_next;
      end
    end
    if (burst_req && !act_free) begin
      pend_on    <= cruise_on_next;
      pend_speed <= target_speed_next;
    end
  end

  // frame output
  assign out_valid = act_valid;
  assign out_data  = build_frame(act_idx, act_on, act_speed);

endmodule
